### src/pairwise_coclustering_counter_assert.svh
// ----------------------------------------------------------------------------
// pairwise co-clustering counter assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_COCLUSTERING_COUNTER_ASSERT_SVH
`define PAIRWISE_COCLUSTERING_COUNTER_ASSERT_SVH

// same-cycle implication
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types and constants of the pairwise co-clustering counter
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned LABELS_W    = 64;
  localparam int unsigned INDEX_BITS  = 3;
  localparam int unsigned OUT_CNT_W   = 16;
  localparam int unsigned SIM_BITS    = 16;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned STEP_BITS   = 4;

  localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic add;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/pairwise_coclustering_counter.sv
// ----------------------------------------------------------------------------
// pairwise_coclustering_counter
// add and clear transactions update the lane counts and the sample total; a read
// starts the 15-step iterative divider behind the per-pair lanes, and the next
// transaction is taken only once its result is loaded into the output register
// reset clears all pair counts, the sample total and the overflow flag at once
// ----------------------------------------------------------------------------
module pairwise_coclustering_counter #(
  parameter int unsigned ITEMS      = 8,
  parameter int unsigned LABEL_BITS = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pcc_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [pcc_pkg::LABELS_W-1:0]       labels_i,
  input  logic [pcc_pkg::INDEX_BITS-1:0]     row_index_i,
  input  logic [pcc_pkg::INDEX_BITS-1:0]     col_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pcc_pkg::OUT_CNT_W-1:0]      pair_count_o,
  output logic [pcc_pkg::SIM_BITS-1:0]       similarity_o,
  output logic                               samples_dropped_o
);

  localparam int unsigned PAIRS = ITEMS * (ITEMS - 1) / 2;
  localparam int unsigned LAB_W = ITEMS * LABEL_BITS;
  localparam int unsigned IDX_W = pcc_pkg::INDEX_BITS + 1;

  pcc_pkg::state_e     state_q, state_d;
  pcc_pkg::lane_ctrl_t lane_ctrl;
  pcc_pkg::div_stat_t  div_stat;

  logic                              in_acc;
  logic                              add_acc;
  logic                              read_acc;
  logic                              clear_acc;
  logic                              full;
  logic                              out_free;
  logic                              load_out;
  logic [COUNT_BITS-1:0]             total_q, total_d;
  logic                              ovf_q, ovf_d;
  logic [LAB_W+pcc_pkg::LABELS_W-1:0] labels_wide;
  logic [LAB_W-1:0]                  labels_ext;
  logic [COUNT_BITS-1:0]             pair_cnt [PAIRS];
  logic [COUNT_BITS-1:0]             pick [PAIRS];
  logic [COUNT_BITS-1:0]             pick_or;
  logic [pcc_pkg::INDEX_BITS-1:0]    rd_lo, rd_hi;
  logic                              in_range;
  logic [COUNT_BITS-1:0]             sel_count;
  logic [COUNT_BITS-1:0]             rd_count_q;
  logic                              rd_drop_q;
  logic [COUNT_BITS+pcc_pkg::OUT_CNT_W-1:0] count_wide;
  logic [pcc_pkg::SIM_BITS-1:0]      quot;
  logic                              out_valid_q;
  logic [pcc_pkg::OUT_CNT_W-1:0]     pair_count_q;
  logic [pcc_pkg::SIM_BITS-1:0]      similarity_q;
  logic                              dropped_q;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign full      = (total_q == {COUNT_BITS{1'b1}});
  assign add_acc   = in_acc && (kind_i == pcc_pkg::KIND_ADD);
  assign read_acc  = in_acc && (kind_i == pcc_pkg::KIND_READ);
  assign clear_acc = in_acc && (kind_i == pcc_pkg::KIND_CLEAR);
  assign out_free  = !out_valid_q || !out_stall_i;

  // label unpacking, bits beyond the field read as zero
  assign labels_wide = {{LAB_W{1'b0}}, labels_i};
  assign labels_ext  = labels_wide[LAB_W-1:0];

  assign lane_ctrl.add   = add_acc && !full;
  assign lane_ctrl.clear = clear_acc;

  assign rd_lo = (row_index_i < col_index_i) ? row_index_i : col_index_i;
  assign rd_hi = (row_index_i < col_index_i) ? col_index_i : row_index_i;

  for (genvar gi = 0; gi < ITEMS - 1; gi++) begin : g_row
    for (genvar gj = gi + 1; gj < ITEMS; gj++) begin : g_col
      localparam int unsigned P = gi * ITEMS - gi * (gi + 1) / 2 + (gj - gi - 1);

      pcc_lane #(
        .LABEL_BITS (LABEL_BITS),
        .COUNT_BITS (COUNT_BITS)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (lane_ctrl),
        .label_a_i (labels_ext[gi*LABEL_BITS +: LABEL_BITS]),
        .label_b_i (labels_ext[gj*LABEL_BITS +: LABEL_BITS]),
        .count_o   (pair_cnt[P])
      );

      assign pick[P] = ((rd_lo == pcc_pkg::INDEX_BITS'(gi)) &&
                        (rd_hi == pcc_pkg::INDEX_BITS'(gj))) ? pair_cnt[P] : '0;
    end
  end

  // merge of the lane counts for a read
  always_comb begin
    pick_or = '0;
    for (int p = 0; p < PAIRS; p++) begin
      pick_or = pick_or | pick[p];
    end
  end

  assign in_range = ({1'b0, row_index_i} < IDX_W'(ITEMS)) &&
                    ({1'b0, col_index_i} < IDX_W'(ITEMS));

  always_comb begin
    if (!in_range) begin
      sel_count = '0;
    end else if (row_index_i == col_index_i) begin
      sel_count = total_q;
    end else begin
      sel_count = pick_or;
    end
  end

  // sample total and overflow flag
  always_comb begin
    total_d = total_q;
    ovf_d   = ovf_q;
    if (clear_acc) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end else if (add_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        total_d = total_q + COUNT_BITS'(1);
      end
    end
  end

  pcc_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (read_acc),
    .dividend_i (sel_count),
    .divisor_i  (total_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcc_pkg::ST_IDLE: begin
        if (read_acc) begin
          state_d = pcc_pkg::ST_DIV;
        end
      end
      pcc_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = out_free ? pcc_pkg::ST_IDLE : pcc_pkg::ST_HOLD;
        end
      end
      pcc_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = pcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      pcc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      pcc_pkg::ST_DIV: begin
        load_out = div_stat.done && out_free;
      end
      pcc_pkg::ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign count_wide = {{pcc_pkg::OUT_CNT_W{1'b0}}, rd_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcc_pkg::ST_IDLE;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      rd_count_q <= sel_count;
      rd_drop_q  <= ovf_q;
    end
    if (load_out) begin
      pair_count_q <= count_wide[pcc_pkg::OUT_CNT_W-1:0];
      similarity_q <= quot;
      dropped_q    <= rd_drop_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pair_count_o      = pair_count_q;
  assign similarity_o      = similarity_q;
  assign samples_dropped_o = dropped_q;

endmodule

### src/pcc_lane.sv
// ----------------------------------------------------------------------------
// pcc_lane
// one pair lane: label compare and co-clustering count register
// ----------------------------------------------------------------------------
module pcc_lane #(
  parameter int unsigned LABEL_BITS = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pcc_pkg::lane_ctrl_t    ctrl_i,
  input  logic [LABEL_BITS-1:0]  label_a_i,
  input  logic [LABEL_BITS-1:0]  label_b_i,
  output logic [COUNT_BITS-1:0]  count_o
);

  logic [COUNT_BITS-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.add && (label_a_i == label_b_i)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

### src/pcc_divider.sv
// ----------------------------------------------------------------------------
// pcc_divider
// iterative restoring divider, one quotient bit per cycle, Q1.15 result
// ----------------------------------------------------------------------------
module pcc_divider #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [COUNT_BITS-1:0]          dividend_i,
  input  logic [COUNT_BITS-1:0]          divisor_i,
  output pcc_pkg::div_stat_t             stat_o,
  output logic [pcc_pkg::SIM_BITS-1:0]   quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [pcc_pkg::STEP_BITS-1:0]   cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]           rem_q, rem_d;
  logic [COUNT_BITS-1:0]           div_q, div_d;
  logic [pcc_pkg::SIM_BITS-1:0]    quot_q, quot_d;
  logic                            zero_q, zero_d;
  logic [COUNT_BITS:0]             rem_dbl;
  logic [COUNT_BITS:0]             rem_sub;
  logic                            fits;
  logic                            top_bit;

  always_comb begin
    rem_dbl = {rem_q, 1'b0};
    rem_sub = rem_dbl - {1'b0, div_q};
    fits    = (rem_dbl >= {1'b0, div_q});
    top_bit = (dividend_i >= divisor_i);
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quot_d  = quot_q;
    zero_d  = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pcc_pkg::STEP_BITS'(pcc_pkg::FRAC_BITS);
      rem_d  = top_bit ? (dividend_i - divisor_i) : dividend_i;
      div_d  = divisor_i;
      quot_d = pcc_pkg::SIM_BITS'(top_bit);
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub[COUNT_BITS-1:0] : rem_dbl[COUNT_BITS-1:0];
      quot_d = {quot_q[pcc_pkg::SIM_BITS-2:0], fits};
      cnt_d  = cnt_q - pcc_pkg::STEP_BITS'(1);
      if (cnt_q == pcc_pkg::STEP_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
    zero_q <= zero_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = zero_q ? '0 : quot_q;

endmodule

### src/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// port-level checks of the pairwise co-clustering counter, bound to the top
// ----------------------------------------------------------------------------
`include "pairwise_coclustering_counter_assert.svh"

module pcc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [pcc_pkg::KIND_BITS-1:0]      kind_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [pcc_pkg::OUT_CNT_W-1:0]      pair_count_o,
  input logic [pcc_pkg::SIM_BITS-1:0]       similarity_o,
  input logic                               samples_dropped_o
);

  // stalled result transaction holds
  `PCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(similarity_o) && $stable(pair_count_o) && $stable(samples_dropped_o), "stalled result changed")

  // fraction never exceeds one
  `PCC_ASSERT_NOW(a_sim_range, out_valid_o, similarity_o <= 16'd32768, "similarity above one")

  // zero count gives zero fraction
  `PCC_ASSERT_NOW(a_sim_zero, out_valid_o && (pair_count_o == '0), similarity_o == '0, "nonzero similarity for zero count")

  // a read transaction occupies the divider
  `PCC_ASSERT_NEXT(a_read_busy, in_valid_i && !in_stall_o && (kind_i == pcc_pkg::KIND_READ), in_stall_o, "input taken during a read")

endmodule

bind pairwise_coclustering_counter pcc_checker u_checker (.*);
